FILE: hw/rtl/ehf_pkg.sv
// ehf_pkg: shared types, constants and register codes of the EMA Hampel filter.
// No dependencies.
package ehf_pkg;

  localparam int HALF_WINDOW_MAX_DEF = 8;
  localparam int SAMPLE_WIDTH_DEF    = 32;

  // configuration register codes
  localparam logic [1:0] REG_GAIN      = 2'd0;
  localparam logic [1:0] REG_HALF_WIN  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam int CFG_DATA_W = 17;

  localparam logic [16:0] GAIN_RESET = 17'd65536;
  localparam logic [16:0] GAIN_ONE   = 17'd65536;
  localparam logic [3:0]  HALF_RESET = 4'd8;
  localparam logic [15:0] THR_RESET  = 16'd768;

  // 256 * 10000 and 1.4826 * 10000
  localparam logic [21:0] LHS_SCALE = 22'd2560000;
  localparam logic [13:0] RHS_SCALE = 14'd14826;

  // controller commands to the datapath
  typedef struct packed {
    logic load_x;
    logic prod;
    logic upd;
    logic ins;
    logic adv;
    logic setup;
    logic step;
    logic mul1;
    logic mul2;
    logic fin;
  } ehf_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic warm_full;
    logic merge_last;
    logic out_free;
  } ehf_status_t;

endpackage

FILE: hw/rtl/ehf_ram.sv
// ehf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ehf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/ehf_ctrl.sv
// ehf_ctrl: sequencing state machine of the EMA Hampel filter.
// Depends on ehf_pkg (command and status structs).
module ehf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ehf_pkg::ehf_status_t st,
  output ehf_pkg::ehf_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROD  = 4'd1;
  localparam logic [3:0] S_UPD   = 4'd2;
  localparam logic [3:0] S_INS   = 4'd3;
  localparam logic [3:0] S_SETUP = 4'd4;
  localparam logic [3:0] S_MERGE = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_nxt  = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_INS;
      end
      S_INS: begin
        cmd.ins = 1'b1;
        if (st.warm_full) begin
          state_nxt = S_SETUP;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        cmd.step = 1'b1;
        if (st.merge_last) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

FILE: hw/rtl/ehf_datapath.sv
// ehf_datapath: EMA, sorted window, deviation merge, outlier test, result register.
// Depends on ehf_pkg and ehf_ram.
module ehf_datapath #(
  parameter int HALF_WINDOW_MAX = ehf_pkg::HALF_WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH    = ehf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_sample,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [ehf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ehf_pkg::ehf_cmd_t                  cmd,
  output ehf_pkg::ehf_status_t               st,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]     out_filtered_value
);

  localparam int W       = SAMPLE_WIDTH;
  localparam int HWM     = HALF_WINDOW_MAX;
  localparam int WIN_MAX = 2 * HWM + 1;
  localparam int AW      = $clog2(WIN_MAX);
  localparam int CW      = $clog2(WIN_MAX + 1);
  localparam int KW      = $clog2(HWM + 1);
  localparam int PW      = W + 19;

  // configuration
  logic [16:0] gain_r;
  logic [3:0]  half_r;
  logic [15:0] thr_r;
  logic        clr;

  assign clr = cfg_we && (cfg_index == ehf_pkg::REG_HALF_WIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= ehf_pkg::GAIN_RESET;
      half_r <= ehf_pkg::HALF_RESET;
      thr_r  <= ehf_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ehf_pkg::REG_GAIN:      gain_r <= cfg_data;
        ehf_pkg::REG_HALF_WIN:  half_r <= cfg_data[3:0];
        ehf_pkg::REG_THRESHOLD: thr_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective k and derived window sizes
  logic [KW-1:0] k_e;
  logic [AW-1:0] two_k;
  logic [AW:0]   n_w;
  always_comb begin
    if (half_r == 4'd0) begin
      k_e = KW'(1);
    end else if (32'(half_r) > HWM) begin
      k_e = KW'(HWM);
    end else begin
      k_e = KW'(half_r);
    end
    two_k = AW'({k_e, 1'b0});
    n_w   = (AW + 1)'({k_e, 1'b1});
  end

  // sequencing counters
  logic [AW-1:0] warm_r, ws_r;
  logic [CW-1:0] cnt_r;
  logic [KW-1:0] step_r;
  logic [AW:0]   ws_inc, ctr_sum;
  logic [AW-1:0] ws_next, centre;

  always_comb begin
    ws_inc  = (AW + 1)'(ws_r) + (AW + 1)'(1);
    ws_next = (ws_inc >= n_w) ? AW'(0) : ws_inc[AW-1:0];
    ctr_sum = (AW + 1)'(ws_r) + (AW + 1)'(k_e) + (AW + 1)'(1);
    centre  = (ctr_sum >= n_w) ? AW'(ctr_sum - n_w) : ctr_sum[AW-1:0];
  end

  // EMA
  logic signed [W-1:0]  x_r, s_r;
  logic signed [PW-1:0] prod_r;
  logic [16:0]          gain_c;
  logic signed [W:0]    xs_diff;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] q;

  always_comb begin
    gain_c  = (gain_r > ehf_pkg::GAIN_ONE) ? ehf_pkg::GAIN_ONE : gain_r;
    xs_diff = $signed({x_r[W-1], x_r}) - $signed({s_r[W-1], s_r});
    rnd     = prod_r + PW'(32768);
    q       = rnd >>> 16;
  end

  logic signed [W-1:0] s_nxt_v;
  assign s_nxt_v = (warm_r == AW'(0)) ? x_r : (s_r + q[W-1:0]);

  // window store of averaged values
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;
  logic signed [W-1:0] rd_val;

  // centre value for the test, then the oldest value for removal
  assign ram_re    = cmd.setup || cmd.mul1;
  assign ram_raddr = cmd.setup ? centre : ws_next;
  assign rd_val    = $signed(ram_rdata);

  ehf_ram #(.WIDTH(W), .DEPTH(WIN_MAX)) u_ram (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (ws_r),
    .wdata (s_nxt_v),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sorted window
  logic signed [W-1:0] srt_r [WIN_MAX];
  logic signed [W-1:0] srt_nxt [WIN_MAX];
  logic [WIN_MAX-1:0]  le_v, eq_v, hit_before;
  logic                found;

  always_comb begin
    for (int i = 0; i < WIN_MAX; i++) begin
      le_v[i] = (CW'(i) < cnt_r) && (srt_r[i] <= s_r);
      eq_v[i] = (CW'(i) < cnt_r) && (srt_r[i] == rd_val);
    end
    hit_before[0] = 1'b0;
    for (int i = 1; i < WIN_MAX; i++) begin
      hit_before[i] = hit_before[i-1] || eq_v[i-1];
    end
    found = |eq_v;
    for (int i = 0; i < WIN_MAX; i++) begin
      srt_nxt[i] = srt_r[i];
      if (cmd.ins) begin
        if (!le_v[i]) begin
          if (i == 0) begin
            srt_nxt[i] = s_r;
          end else if (le_v[i-1]) begin
            srt_nxt[i] = s_r;
          end else begin
            srt_nxt[i] = srt_r[i-1];
          end
        end
      end else if (cmd.fin) begin
        if ((hit_before[i] || eq_v[i]) && (i + 1 < WIN_MAX)) begin
          srt_nxt[i] = srt_r[(i + 1) % WIN_MAX];
        end
      end
    end
  end

  // deviation merge: left and right halves around the median
  logic signed [W-1:0] med_r;
  logic signed [W-1:0] lft_r [HWM];
  logic signed [W-1:0] rgt_r [HWM];
  logic signed [W-1:0] lft_nxt [HWM];
  logic signed [W-1:0] rgt_nxt [HWM];
  logic [W-1:0]        mad_r;
  logic [W:0]          dl, dr;
  logic                take_l;

  always_comb begin
    dl     = $unsigned({med_r[W-1], med_r}) - $unsigned({lft_r[0][W-1], lft_r[0]});
    dr     = $unsigned({rgt_r[0][W-1], rgt_r[0]}) - $unsigned({med_r[W-1], med_r});
    take_l = (dl[W-1:0] <= dr[W-1:0]);
    for (int i = 0; i < HWM; i++) begin
      lft_nxt[i] = lft_r[i];
      rgt_nxt[i] = rgt_r[i];
      if (cmd.setup) begin
        if (i < int'(k_e)) begin
          lft_nxt[i] = srt_r[AW'(int'(k_e) - 1 - i)];
        end
        if (i + int'(k_e) + 1 < WIN_MAX) begin
          rgt_nxt[i] = srt_r[AW'(int'(k_e) + 1 + i)];
        end
      end else if (cmd.step) begin
        if (take_l && (i + 1 < HWM)) begin
          lft_nxt[i] = lft_r[(i + 1) % HWM];
        end
        if (!take_l && (i + 1 < HWM)) begin
          rgt_nxt[i] = rgt_r[(i + 1) % HWM];
        end
      end
    end
  end

  // outlier test
  logic [W+21:0]       lhs_r;
  logic [29:0]         rt_r;
  logic [W+29:0]       rhs_r;
  logic signed [W-1:0] cand_r;
  logic [W:0]          cd;
  logic [W-1:0]        cdev;

  always_comb begin
    cd   = $unsigned({rd_val[W-1], rd_val}) - $unsigned({med_r[W-1], med_r});
    cdev = cd[W] ? W'(-cd) : cd[W-1:0];
  end

  // result register
  logic                out_valid_r;
  logic signed [W-1:0] out_r;

  // control-state registers
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      warm_r <= '0;
      ws_r   <= '0;
      cnt_r  <= '0;
      s_r    <= '0;
    end else begin
      if (cmd.upd) begin
        s_r <= s_nxt_v;
      end
      if (cmd.ins) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.adv) begin
        warm_r <= warm_r + AW'(1);
        ws_r   <= ws_next;
      end
      if (cmd.fin) begin
        ws_r <= ws_next;
        if (found) begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.setup) begin
        step_r <= '0;
      end else if (cmd.step) begin
        step_r <= step_r + KW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_MAX; i++) begin
      srt_r[i] <= srt_nxt[i];
    end
    for (int i = 0; i < HWM; i++) begin
      lft_r[i] <= lft_nxt[i];
      rgt_r[i] <= rgt_nxt[i];
    end
    if (cmd.load_x) begin
      x_r <= in_sample;
    end
    if (cmd.prod) begin
      prod_r <= PW'(xs_diff * $signed({1'b0, gain_c}));
    end
    if (cmd.setup) begin
      med_r <= srt_r[AW'(k_e)];
    end
    if (cmd.step) begin
      mad_r <= take_l ? dl[W-1:0] : dr[W-1:0];
    end
    if (cmd.mul1) begin
      lhs_r  <= (W + 22)'(cdev) * (W + 22)'(ehf_pkg::LHS_SCALE);
      rt_r   <= 30'(thr_r) * 30'(ehf_pkg::RHS_SCALE);
      cand_r <= rd_val;
    end
    if (cmd.mul2) begin
      rhs_r <= (W + 30)'(rt_r) * (W + 30)'(mad_r);
    end
    if (cmd.fin) begin
      out_r <= ((W + 30)'(lhs_r) <= rhs_r) ? cand_r : med_r;
    end
  end

  assign st.warm_full  = (warm_r == two_k);
  assign st.merge_last = (step_r == (k_e - KW'(1)));
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_r;

endmodule

FILE: hw/rtl/ema_hampel_filter.sv
// ema_hampel_filter: top level, joins the controller and the datapath.
// Depends on ehf_pkg, ehf_ctrl, ehf_datapath (which holds ehf_ram).
//
// Each sample updates an exponential moving average (the first sample after
// reset or a half_window write seeds it); averaged values fill a window of
// 2k+1 entries kept sorted in registers. After the first 2k samples every
// sample yields one result: the centre value k back if its distance from the
// window median is within threshold*1.4826*MAD (threshold 8.8 fixed point),
// else the median. A sample is taken only in idle and passes the product,
// update and insert states, with a full window also setup, the k-step merge
// over the sorted window's two halves, mul1, mul2 and the final state, which
// waits while the previous result is held. Configuration writes are taken at
// any time; writing half_window restarts the filter with registers kept.
module ema_hampel_filter #(
  parameter int HALF_WINDOW_MAX = ehf_pkg::HALF_WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH    = ehf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [ehf_pkg::CFG_DATA_W-1:0] cfg_data
);

  ehf_pkg::ehf_cmd_t    cmd;
  ehf_pkg::ehf_status_t st;

  assign cfg_ready = 1'b1;

  ehf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ehf_datapath #(
    .HALF_WINDOW_MAX (HALF_WINDOW_MAX),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_sample          (in_sample),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value)
  );

  // an accepted beat keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in progress");

  // a new result comes only from an item in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in progress");

  // the result register is loaded only when free
  a_fin_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> st.out_free)
    else $error("result overwritten before delivery");

endmodule
